@@ src/sif_pkg.sv @@
// ----------------------------------------------------------------------------
// sif_pkg
// Types and constants shared by the stateful ingress flow filter.
// ----------------------------------------------------------------------------
package sif_pkg;

	localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;
	localparam logic [3:0]  IPV4_VERSION   = 4'd4;
	localparam logic [15:0] L4_BYTES       = 16'd54;
	localparam logic [5:0]  MAX_PREFIX     = 6'd32;

	localparam logic [2:0] RSN_NOT_CHECKED = 3'd0;
	localparam logic [2:0] RSN_EXISTING    = 3'd1;
	localparam logic [2:0] RSN_REPLY       = 3'd2;
	localparam logic [2:0] RSN_NO_RULE     = 3'd3;
	localparam logic [2:0] RSN_ACCEPT      = 3'd4;
	localparam logic [2:0] RSN_DENY        = 3'd5;
	localparam logic [2:0] RSN_WRITTEN     = 3'd6;

	typedef enum logic [1:0] {
		JOB_WRITE,
		JOB_PASS,
		JOB_LOOKUP
	} job_kind_t;

	typedef struct packed {
		logic        req_type;
		logic [15:0] frame_length;
		logic [15:0] ether_type;
		logic [3:0]  ip_version;
		logic [7:0]  protocol;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] l4_src;
		logic [15:0] l4_dst;
		logic [6:0]  rule_index;
		logic [5:0]  rule_prefix_len;
		logic        rule_enable;
	} in_t;

	typedef struct packed {
		logic        verdict;
		logic [2:0]  reason;
		logic        event_valid;
		logic [31:0] event_src_ip;
		logic [31:0] event_dst_ip;
		logic [15:0] event_src_port;
		logic [15:0] event_dst_port;
		logic [7:0]  event_protocol;
		logic        conn_inserted;
	} out_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  protocol;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] l4_src;
		logic [15:0] l4_dst;
		logic [6:0]  rule_index;
		logic [5:0]  pfx_len;
		logic        enable;
	} job_t;

	typedef struct packed {
		logic [5:0]  pfx_len;
		logic [7:0]  protocol;
		logic [15:0] port_lo;
		logic [15:0] port_hi;
	} rule_t;

endpackage

@@ src/sif_front.sv @@
// ----------------------------------------------------------------------------
// sif_front
// Classifies incoming requests into queue jobs and byte-swaps the L4 ports of packet headers.
// ----------------------------------------------------------------------------
module sif_front (
	input  sif_pkg::in_t  req,
	output sif_pkg::job_t job
);
	import sif_pkg::*;

	logic checkable;

	assign checkable = (req.frame_length >= L4_BYTES) && (req.ether_type == IPV4_ETHERTYPE)
		&& (req.ip_version == IPV4_VERSION);

	always_comb begin
		job.protocol   = req.protocol;
		job.src_ip     = req.src_ip;
		job.dst_ip     = req.dst_ip;
		job.rule_index = req.rule_index;
		job.pfx_len    = (req.rule_prefix_len > MAX_PREFIX) ? MAX_PREFIX : req.rule_prefix_len;
		job.enable     = req.rule_enable;
		if (req.req_type) begin
			job.kind   = JOB_WRITE;
			job.l4_src = req.l4_src;
			job.l4_dst = req.l4_dst;
		end else begin
			job.kind   = checkable ? JOB_LOOKUP : JOB_PASS;
			job.l4_src = {req.l4_src[7:0], req.l4_src[15:8]};
			job.l4_dst = {req.l4_dst[7:0], req.l4_dst[15:8]};
		end
	end

endmodule

@@ src/sif_queue.sv @@
// ----------------------------------------------------------------------------
// sif_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module sif_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sif_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output sif_pkg::job_t head
);
	import sif_pkg::*;

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ src/sif_back.sv @@
// ----------------------------------------------------------------------------
// sif_back
// Runs one job (rule write, table scans or pass) and registers the result.
// ----------------------------------------------------------------------------
module sif_back #(
	parameter int RULE_ENTRIES = 128,
	parameter int CONN_ENTRIES = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  sif_pkg::job_t job,
	output logic          job_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output sif_pkg::out_t out_data
);
	import sif_pkg::*;

	localparam int RW = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
	localparam int CW = (CONN_ENTRIES > 1) ? $clog2(CONN_ENTRIES) : 1;
	localparam int NW = ((RW > CW) ? RW : CW) + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CSCAN,
		ST_RSCAN,
		ST_FINISH
	} state_t;

	state_t st_q;
	job_t   job_q;

	logic [31:0] rule_pfx_mem [RULE_ENTRIES];
	rule_t       rule_mem     [RULE_ENTRIES];
	logic [63:0] conn_a_mem   [CONN_ENTRIES];
	logic [39:0] conn_p_mem   [CONN_ENTRIES];
	logic [RULE_ENTRIES-1:0] rule_valid_q;
	logic [CONN_ENTRIES-1:0] conn_valid_q;

	logic [NW-1:0] cnt_q;
	logic          chk_s1;
	logic          ent_v_s1;
	logic [NW-1:0] idx_s1;
	logic [31:0]   pfx_s1;
	rule_t         rule_s1;
	logic [63:0]   ca_s1;
	logic [39:0]   cp_s1;

	logic          fwd_hit_q;
	logic          rev_hit_q;
	logic          free_found_q;
	logic [CW-1:0] free_idx_q;
	logic          best_found_q;
	rule_t         best_q;

	logic [RW-1:0] ridx;
	logic [CW-1:0] cidx;
	logic [63:0]   fwd_a;
	logic [39:0]   fwd_p;
	logic [63:0]   rev_a;
	logic [39:0]   rev_p;
	logic [31:0]   mask;
	logic          pfx_hit;
	logic          out_free;
	logic          finish;
	logic          rule_ok;
	logic          do_insert;
	logic          do_rwrite;
	logic [RW-1:0] waddr;
	out_t          res;

	assign ridx  = cnt_q[RW-1:0];
	assign cidx  = cnt_q[CW-1:0];
	assign fwd_a = {job_q.src_ip, job_q.dst_ip};
	assign fwd_p = {job_q.l4_src, job_q.l4_dst, job_q.protocol};
	assign rev_a = {job_q.dst_ip, job_q.src_ip};
	assign rev_p = {job_q.l4_dst, job_q.l4_src, job_q.protocol};
	assign mask  = (rule_s1.pfx_len == 6'd0) ? 32'd0
		: (32'hFFFF_FFFF << (6'd32 - rule_s1.pfx_len));
	assign pfx_hit  = (((job_q.src_ip ^ pfx_s1) & mask) == 32'd0);
	assign out_free = !out_valid || !out_stall;
	assign finish   = (st_q == ST_FINISH) && out_free;
	assign job_pop  = (st_q == ST_IDLE) && job_valid;
	assign rule_ok  = (best_q.protocol == job_q.protocol)
		&& (job_q.l4_src >= best_q.port_lo) && (job_q.l4_src <= best_q.port_hi);
	assign waddr    = RW'(job_q.rule_index);
	assign do_rwrite = finish && (job_q.kind == JOB_WRITE)
		&& ({25'd0, job_q.rule_index} < RULE_ENTRIES);
	assign do_insert = finish && (job_q.kind == JOB_LOOKUP) && !fwd_hit_q && !rev_hit_q
		&& best_found_q && rule_ok && free_found_q;

	always_comb begin
		res = '0;
		res.verdict = 1'b1;
		case (job_q.kind)
			JOB_WRITE: begin
				res.reason = RSN_WRITTEN;
			end
			JOB_LOOKUP: begin
				if (fwd_hit_q) begin
					res.reason = RSN_EXISTING;
				end else if (rev_hit_q) begin
					res.reason = RSN_REPLY;
				end else if (!best_found_q) begin
					res.verdict = 1'b0;
					res.reason  = RSN_NO_RULE;
				end else begin
					res.event_valid    = 1'b1;
					res.event_src_ip   = job_q.src_ip;
					res.event_dst_ip   = job_q.dst_ip;
					res.event_src_port = job_q.l4_src;
					res.event_dst_port = job_q.l4_dst;
					res.event_protocol = job_q.protocol;
					if (rule_ok) begin
						res.reason        = RSN_ACCEPT;
						res.conn_inserted = free_found_q;
					end else begin
						res.verdict = 1'b0;
						res.reason  = RSN_DENY;
					end
				end
			end
			default: begin
				res.reason = RSN_NOT_CHECKED;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		pfx_s1  <= rule_pfx_mem[ridx];
		rule_s1 <= rule_mem[ridx];
		ca_s1   <= conn_a_mem[cidx];
		cp_s1   <= conn_p_mem[cidx];
		if (do_rwrite && job_q.enable) begin
			rule_pfx_mem[waddr] <= job_q.src_ip;
			rule_mem[waddr]     <= '{job_q.pfx_len, job_q.protocol,
				job_q.l4_src, job_q.l4_dst};
		end
		if (do_insert) begin
			conn_a_mem[free_idx_q] <= fwd_a;
			conn_p_mem[free_idx_q] <= fwd_p;
		end
		if (job_pop) begin
			job_q <= job;
		end
		if (finish) begin
			out_data <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			cnt_q        <= '0;
			chk_s1       <= 1'b0;
			ent_v_s1     <= 1'b0;
			idx_s1       <= '0;
			fwd_hit_q    <= 1'b0;
			rev_hit_q    <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			best_found_q <= 1'b0;
			best_q       <= '0;
			rule_valid_q <= '0;
			conn_valid_q <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (finish) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (do_rwrite) begin
				rule_valid_q[waddr] <= job_q.enable;
			end
			if (do_insert) begin
				conn_valid_q[free_idx_q] <= 1'b1;
			end
			case (st_q)
				ST_IDLE: begin
					cnt_q        <= '0;
					chk_s1       <= 1'b0;
					fwd_hit_q    <= 1'b0;
					rev_hit_q    <= 1'b0;
					free_found_q <= 1'b0;
					best_found_q <= 1'b0;
					if (job_valid) begin
						st_q <= (job.kind == JOB_LOOKUP) ? ST_CSCAN : ST_FINISH;
					end
				end
				ST_CSCAN: begin
					if (chk_s1) begin
						if (ent_v_s1) begin
							if (ca_s1 == fwd_a && cp_s1 == fwd_p) begin
								fwd_hit_q <= 1'b1;
							end
							if (ca_s1 == rev_a && cp_s1 == rev_p) begin
								rev_hit_q <= 1'b1;
							end
						end else if (!free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_s1[CW-1:0];
						end
					end
					if (cnt_q != NW'(CONN_ENTRIES)) begin
						chk_s1   <= 1'b1;
						ent_v_s1 <= conn_valid_q[cidx];
						idx_s1   <= cnt_q;
						cnt_q    <= cnt_q + NW'(1);
					end else begin
						chk_s1 <= 1'b0;
						if (!chk_s1) begin
							cnt_q <= '0;
							st_q  <= (fwd_hit_q || rev_hit_q) ? ST_FINISH : ST_RSCAN;
						end
					end
				end
				ST_RSCAN: begin
					if (chk_s1 && ent_v_s1 && pfx_hit
						&& (!best_found_q || rule_s1.pfx_len > best_q.pfx_len)) begin
						best_found_q <= 1'b1;
						best_q       <= rule_s1;
					end
					if (cnt_q != NW'(RULE_ENTRIES)) begin
						chk_s1   <= 1'b1;
						ent_v_s1 <= rule_valid_q[ridx];
						idx_s1   <= cnt_q;
						cnt_q    <= cnt_q + NW'(1);
					end else begin
						chk_s1 <= 1'b0;
						if (!chk_s1) begin
							st_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/stateful_ingress_flow_filter_top.sv @@
// ----------------------------------------------------------------------------
// stateful_ingress_flow_filter_top
// Stateful ingress filter: rule writes and packet header classification.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one request per beat: either
// a rule write or a packet header. Output channel out_valid/out_stall/out_data
// returns exactly one result beat per request, in request order.
// The front classifies each beat and byte-swaps the L4 ports of packet headers
// in the same cycle it is taken; a two-entry queue holds jobs for the back part.
// A rule write or unchecked frame goes from idle straight to registering its result.
// A checked header scans the connection table one entry per cycle and, when no
// connection matches, the rule table one entry per cycle, then registers the
// result; the scan rate is set by the single read port of each table.
// The back part handles one job at a time.
// Reset clears all rule and connection valid bits and empties the queue; no
// clearing pass is needed. When the receiver stalls, the result holds in the
// output register, the back part waits, and in_stall rises once the queue fills.
// ----------------------------------------------------------------------------
module stateful_ingress_flow_filter_top #(
	parameter int RULE_ENTRIES = 128,
	parameter int CONN_ENTRIES = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  sif_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output sif_pkg::out_t out_data
);
	import sif_pkg::*;

	job_t front_job;
	job_t head_job;
	logic q_full;
	logic q_valid;
	logic q_pop;

	assign in_stall = q_full;

	sif_front u_front (
		.req (in_data),
		.job (front_job)
	);

	sif_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.push_job  (front_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (head_job)
	);

	sif_back #(
		.RULE_ENTRIES (RULE_ENTRIES),
		.CONN_ENTRIES (CONN_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (head_job),
		.job_pop   (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
